// ===== design/cube_slice_stats_rms_core_defines.svh =====
// Assertion macros used by the checker file of the block.
`ifndef CUBE_SLICE_STATS_RMS_CORE_DEFINES_SVH
`define CUBE_SLICE_STATS_RMS_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSSR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/cssr_pkg.sv =====
`default_nettype none
package cssr_pkg;

	localparam int SAMPLE_W = 24;
	localparam int PLANE_W = 25;
	localparam int SLICES_W = 13;
	localparam int PIX_W = PLANE_W - 1;
	localparam int IDX_W = SLICES_W - 1;
	localparam int CNT_W = 36;
	localparam int SUM_W = 64;
	localparam int SQ_W = 2 * SAMPLE_W;
	localparam int ROOT_W = SUM_W / 2;
	localparam int RMS_W = 23;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [PLANE_W-1:0] MAX_PLANE = PLANE_W'(1) << PIX_W;
	localparam logic [SLICES_W-1:0] MAX_SLICES = SLICES_W'(1) << IDX_W;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam logic [RMS_W-1:0] RMS_MAX = '1;

	localparam logic KIND_SLICE = 1'b0;
	localparam logic KIND_CUBE = 1'b1;

	typedef struct packed {
		logic take;
		logic div_start;
		logic sqrt_start;
		logic cube_load;
	} cmd_t;

	typedef struct packed {
		logic end_slice;
		logic end_cube;
		logic div_busy;
		logic sqrt_busy;
	} stat_t;

	typedef struct packed {
		logic kind;
		logic [IDX_W-1:0] slice_index;
		logic signed [SAMPLE_W-1:0] min_value;
		logic signed [SAMPLE_W-1:0] max_value;
		logic any_valid;
		logic [CNT_W-1:0] blank_count;
		logic [RMS_W-1:0] rms_value;
		logic sum_saturated;
		logic last;
	} res_t;

endpackage
`default_nettype wire

// ===== design/cssr_if.sv =====
`default_nettype none
interface cssr_in_if
	import cssr_pkg::*;
();
	logic valid;
	logic ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic blank;

	modport source (output valid, output sample, output blank, input ready);
	modport sink (input valid, input sample, input blank, output ready);
endinterface

interface cssr_out_if
	import cssr_pkg::*;
();
	logic valid;
	logic ready;
	logic kind;
	logic [IDX_W-1:0] slice_index;
	logic signed [SAMPLE_W-1:0] min_value;
	logic signed [SAMPLE_W-1:0] max_value;
	logic any_valid;
	logic [CNT_W-1:0] blank_count;
	logic [RMS_W-1:0] rms_value;
	logic sum_saturated;
	logic last;

	modport source (
		output valid, output kind, output slice_index, output min_value, output max_value,
		output any_valid, output blank_count, output rms_value, output sum_saturated,
		output last, input ready
	);
	modport sink (
		input valid, input kind, input slice_index, input min_value, input max_value,
		input any_valid, input blank_count, input rms_value, input sum_saturated,
		input last, output ready
	);
endinterface
`default_nettype wire

// ===== design/cssr_regs.sv =====
`default_nettype none
module cssr_regs
	import cssr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ADDR_W-1:0] paddr,
	input wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready,
	output logic [PLANE_W-1:0] plane,
	output logic [SLICES_W-1:0] slices
);
	localparam logic REG_PLANE_SIZE = 1'b0;
	localparam logic REG_SLICE_COUNT = 1'b1;

	logic [PLANE_W-1:0] plane_q;
	logic [SLICES_W-1:0] slices_q;
	logic reg_idx;
	logic wr_en;

	assign pready = 1'b1;
	assign reg_idx = paddr[ADDR_W-1];
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= PLANE_W'(1);
			slices_q <= SLICES_W'(1);
		end else if (wr_en) begin
			case (reg_idx)
				REG_PLANE_SIZE: plane_q <= pwdata[PLANE_W-1:0];
				REG_SLICE_COUNT: slices_q <= pwdata[SLICES_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PLANE_SIZE: prdata = DATA_W'(plane_q);
			REG_SLICE_COUNT: prdata = DATA_W'(slices_q);
			default: prdata = '0;
		endcase
	end

	assign plane = (plane_q == '0) ? PLANE_W'(1) :
		((plane_q > MAX_PLANE) ? MAX_PLANE : plane_q);
	assign slices = (slices_q == '0) ? SLICES_W'(1) :
		((slices_q > MAX_SLICES) ? MAX_SLICES : slices_q);
endmodule
`default_nettype wire

// ===== design/cssr_div.sv =====
`default_nettype none
module cssr_div
	import cssr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [SUM_W-1:0] dividend,
	input wire logic [CNT_W-1:0] divisor,
	output logic busy,
	output logic [SUM_W-1:0] quotient
);
	localparam int STEP_W = $clog2(SUM_W);

	logic busy_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0] dq_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] dvs_q;
	logic [CNT_W:0] shifted;
	logic [CNT_W:0] diff;
	logic fits;

	assign shifted = {rem_q, dq_q[SUM_W-1]};
	assign fits = shifted >= {1'b0, dvs_q};
	assign diff = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '1;
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end
			step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q <= {dq_q[SUM_W-2:0], fits};
			rem_q <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quotient = dq_q;
endmodule
`default_nettype wire

// ===== design/cssr_sqrt.sv =====
`default_nettype none
module cssr_sqrt
	import cssr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [SUM_W-1:0] radicand,
	output logic busy,
	output logic [ROOT_W-1:0] root
);
	localparam int STEP_W = $clog2(ROOT_W);
	localparam int REM_W = ROOT_W + 2;

	logic busy_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0] v_q;
	logic [REM_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W+1:0] shifted;
	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] diff;
	logic fits;

	assign shifted = {rem_q, v_q[SUM_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fits = shifted >= trial;
	assign diff = shifted - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '1;
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end
			step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q <= {v_q[SUM_W-3:0], 2'b00};
			rem_q <= fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign root = root_q;
endmodule
`default_nettype wire

// ===== design/cssr_dp.sv =====
`default_nettype none
module cssr_dp
	import cssr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire cmd_t cmd,
	output stat_t stat,
	input wire logic [PLANE_W-1:0] plane,
	input wire logic [SLICES_W-1:0] slices,
	input wire logic signed [SAMPLE_W-1:0] sample,
	input wire logic blank,
	output res_t res
);
	logic [PIX_W-1:0] pix_q;
	logic [IDX_W-1:0] slice_q;
	logic signed [SAMPLE_W-1:0] slice_min_q;
	logic signed [SAMPLE_W-1:0] slice_max_q;
	logic slice_any_q;
	logic signed [SAMPLE_W-1:0] cube_min_q;
	logic signed [SAMPLE_W-1:0] cube_max_q;
	logic cube_any_q;
	logic [CNT_W-1:0] blank_cnt_q;
	logic [CNT_W-1:0] valid_cnt_q;
	logic [SUM_W-1:0] sum_q;
	logic sat_q;
	logic acc_s1;
	logic [SQ_W-1:0] sq_s1;
	res_t res_q;

	logic [SAMPLE_W-1:0] sample_u;
	logic [SAMPLE_W-1:0] mag;
	logic [SQ_W-1:0] sq;
	logic [PLANE_W-1:0] pix_next;
	logic [SLICES_W-1:0] slice_next;
	logic end_slice;
	logic end_cube;
	logic signed [SAMPLE_W-1:0] slice_min_new;
	logic signed [SAMPLE_W-1:0] slice_max_new;
	logic signed [SAMPLE_W-1:0] cube_min_new;
	logic signed [SAMPLE_W-1:0] cube_max_new;
	logic [SUM_W:0] sum_ext;
	logic [SUM_W-1:0] quot;
	logic [ROOT_W-1:0] root;
	logic [RMS_W-1:0] rms;
	logic div_busy;
	logic sqrt_busy;

	assign sample_u = $unsigned(sample);
	assign mag = sample_u[SAMPLE_W-1] ? (~sample_u + 1'b1) : sample_u;
	assign sq = SQ_W'(mag) * SQ_W'(mag);

	assign pix_next = {1'b0, pix_q} + 1'b1;
	assign slice_next = {1'b0, slice_q} + 1'b1;
	assign end_slice = pix_next >= plane;
	assign end_cube = slice_next >= slices;

	assign slice_min_new = (!blank && (sample < slice_min_q)) ? sample : slice_min_q;
	assign slice_max_new = (!blank && (sample > slice_max_q)) ? sample : slice_max_q;
	assign cube_min_new = (!blank && (sample < cube_min_q)) ? sample : cube_min_q;
	assign cube_max_new = (!blank && (sample > cube_max_q)) ? sample : cube_max_q;

	assign sum_ext = {1'b0, sum_q} + (SUM_W+1)'(sq_s1);

	assign rms = (valid_cnt_q == '0) ? '0 :
		((|root[ROOT_W-1:RMS_W]) ? RMS_MAX : root[RMS_W-1:0]);

	cssr_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.dividend(sum_q),
		.divisor(valid_cnt_q),
		.busy(div_busy),
		.quotient(quot)
	);

	cssr_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.sqrt_start),
		.radicand(quot),
		.busy(sqrt_busy),
		.root(root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
			slice_q <= '0;
			slice_min_q <= SAMPLE_MAX;
			slice_max_q <= SAMPLE_MIN;
			slice_any_q <= 1'b0;
			cube_min_q <= SAMPLE_MAX;
			cube_max_q <= SAMPLE_MIN;
			cube_any_q <= 1'b0;
			blank_cnt_q <= '0;
			valid_cnt_q <= '0;
			sum_q <= '0;
			sat_q <= 1'b0;
			acc_s1 <= 1'b0;
		end else begin
			acc_s1 <= cmd.take && !blank;
			if (cmd.take) begin
				cube_min_q <= cube_min_new;
				cube_max_q <= cube_max_new;
				if (blank) begin
					if (blank_cnt_q != CNT_MAX) begin
						blank_cnt_q <= blank_cnt_q + 1'b1;
					end
				end else begin
					cube_any_q <= 1'b1;
					if (valid_cnt_q != CNT_MAX) begin
						valid_cnt_q <= valid_cnt_q + 1'b1;
					end
				end
				if (end_slice) begin
					pix_q <= '0;
					slice_q <= end_cube ? '0 : slice_next[IDX_W-1:0];
					slice_min_q <= SAMPLE_MAX;
					slice_max_q <= SAMPLE_MIN;
					slice_any_q <= 1'b0;
				end else begin
					pix_q <= pix_next[PIX_W-1:0];
					slice_min_q <= slice_min_new;
					slice_max_q <= slice_max_new;
					slice_any_q <= slice_any_q || !blank;
				end
			end
			if (acc_s1) begin
				if (sum_ext[SUM_W]) begin
					sum_q <= SUM_MAX;
					sat_q <= 1'b1;
				end else begin
					sum_q <= sum_ext[SUM_W-1:0];
				end
			end
			if (cmd.cube_load) begin
				cube_min_q <= SAMPLE_MAX;
				cube_max_q <= SAMPLE_MIN;
				cube_any_q <= 1'b0;
				blank_cnt_q <= '0;
				valid_cnt_q <= '0;
				sum_q <= '0;
				sat_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		sq_s1 <= sq;
		if (cmd.take && end_slice) begin
			res_q.kind <= KIND_SLICE;
			res_q.slice_index <= slice_q;
			res_q.min_value <= slice_min_new;
			res_q.max_value <= slice_max_new;
			res_q.any_valid <= slice_any_q || !blank;
			res_q.blank_count <= '0;
			res_q.rms_value <= '0;
			res_q.sum_saturated <= 1'b0;
			res_q.last <= !end_cube;
		end else if (cmd.cube_load) begin
			res_q.kind <= KIND_CUBE;
			res_q.slice_index <= '0;
			res_q.min_value <= cube_min_q;
			res_q.max_value <= cube_max_q;
			res_q.any_valid <= cube_any_q;
			res_q.blank_count <= blank_cnt_q;
			res_q.rms_value <= rms;
			res_q.sum_saturated <= sat_q;
			res_q.last <= 1'b1;
		end
	end

	assign stat.end_slice = end_slice;
	assign stat.end_cube = end_cube;
	assign stat.div_busy = div_busy;
	assign stat.sqrt_busy = sqrt_busy;
	assign res = res_q;
endmodule
`default_nettype wire

// ===== design/cssr_ctrl.sv =====
`default_nettype none
module cssr_ctrl
	import cssr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire stat_t stat,
	output cmd_t cmd
);
	typedef enum logic [2:0] {
		ST_RUN,
		ST_SLICE,
		ST_DIV_LOAD,
		ST_DIV,
		ST_SQRT,
		ST_CUBE
	} state_t;

	state_t state_q;
	logic cube_pend_q;

	assign in_ready = (state_q == ST_RUN);
	assign out_valid = (state_q == ST_SLICE) || (state_q == ST_CUBE);
	assign cmd.take = in_ready && in_valid;
	assign cmd.div_start = (state_q == ST_DIV_LOAD);
	assign cmd.sqrt_start = (state_q == ST_DIV) && !stat.div_busy;
	assign cmd.cube_load = (state_q == ST_SQRT) && !stat.sqrt_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			cube_pend_q <= 1'b0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (cmd.take && stat.end_slice) begin
						state_q <= ST_SLICE;
						cube_pend_q <= stat.end_cube;
					end
				end
				ST_SLICE: begin
					if (out_ready) begin
						state_q <= cube_pend_q ? ST_DIV_LOAD : ST_RUN;
					end
				end
				ST_DIV_LOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (!stat.div_busy) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (!stat.sqrt_busy) begin
						state_q <= ST_CUBE;
					end
				end
				ST_CUBE: begin
					if (out_ready) begin
						state_q <= ST_RUN;
						cube_pend_q <= 1'b0;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== design/cube_slice_stats_rms_core.sv =====
// Running slice and cube statistics over a pixel stream in raster order.
// Pixels enter on the pixels channel (sample in Q16.8, blank flag) and
// summaries leave on the results channel; each moves by a valid/ready transfer.
// Pixels that do not end a slice stream at one per cycle. A pixel that ends
// a slice makes the slice summary valid in the next cycle, and no pixel is
// taken until that summary is transferred. When the slice also ends the cube,
// a divider and then a square root unit compute the RMS after the slice
// transfer; the cube summary is valid once both are done, and it carries last.
// The plane_size and slice_count registers sit on the APB port. The user must
// see that they are written only while no cube is in progress; the block
// itself does not enforce this. Reset returns all statistics to their empty
// values and sets both registers to 1. While the receiver holds ready low,
// the summary and the control state hold.
`default_nettype none
module cube_slice_stats_rms_core
	import cssr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	cssr_in_if.sink pixels,
	cssr_out_if.source results,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ADDR_W-1:0] paddr,
	input wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready
);
	logic [PLANE_W-1:0] plane;
	logic [SLICES_W-1:0] slices;
	cmd_t cmd;
	stat_t stat;
	res_t res;
	logic in_ready;
	logic out_valid;

	cssr_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.plane(plane),
		.slices(slices)
	);

	cssr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(pixels.valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(results.ready),
		.stat(stat),
		.cmd(cmd)
	);

	cssr_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.plane(plane),
		.slices(slices),
		.sample(pixels.sample),
		.blank(pixels.blank),
		.res(res)
	);

	assign pixels.ready = in_ready;
	assign results.valid = out_valid;
	assign results.kind = res.kind;
	assign results.slice_index = res.slice_index;
	assign results.min_value = res.min_value;
	assign results.max_value = res.max_value;
	assign results.any_valid = res.any_valid;
	assign results.blank_count = res.blank_count;
	assign results.rms_value = res.rms_value;
	assign results.sum_saturated = res.sum_saturated;
	assign results.last = res.last;
endmodule
`default_nettype wire

// ===== design/cssr_chk.sv =====
`default_nettype none
`include "cube_slice_stats_rms_core_defines.svh"
module cssr_chk
	import cssr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic out_kind,
	input wire logic [IDX_W-1:0] out_slice_index,
	input wire logic signed [SAMPLE_W-1:0] out_min,
	input wire logic signed [SAMPLE_W-1:0] out_max,
	input wire logic out_any,
	input wire logic [CNT_W-1:0] out_blank_count,
	input wire logic [RMS_W-1:0] out_rms,
	input wire logic out_sat,
	input wire logic out_last
);
	`CSSR_ASSERT_NEXT(a_result_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_min) && $stable(out_max) && $stable(out_last), "stalled result changed")
	`CSSR_ASSERT_SAME(a_no_overlap, clk, arst_n, out_valid, !in_ready, "pixel taken while a result waits")
	`CSSR_ASSERT_SAME(a_cube_last, clk, arst_n, out_valid && (out_kind == KIND_CUBE), out_last && (out_slice_index == '0), "cube summary without last")
	`CSSR_ASSERT_SAME(a_slice_zeros, clk, arst_n, out_valid && (out_kind == KIND_SLICE), (out_blank_count == '0) && (out_rms == '0) && !out_sat, "slice summary carries cube fields")
	`CSSR_ASSERT_SAME(a_empty_extremes, clk, arst_n, out_valid && !out_any, (out_min == SAMPLE_MAX) && (out_max == SAMPLE_MIN), "empty summary with extremes")
endmodule

bind cube_slice_stats_rms_core cssr_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(pixels.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.out_kind(results.kind),
	.out_slice_index(results.slice_index),
	.out_min(results.min_value),
	.out_max(results.max_value),
	.out_any(results.any_valid),
	.out_blank_count(results.blank_count),
	.out_rms(results.rms_value),
	.out_sat(results.sum_saturated),
	.out_last(results.last)
);
`default_nettype wire

// ===== tb/cssr_stats_pkg.sv =====
package cssr_stats_pkg;
	import cssr_pkg::*;

	localparam int REG_PLANE_SIZE = 0;
	localparam int REG_SLICE_COUNT = 1;

	class cube_stats_board;
		logic [PLANE_W-1:0] plane_size;
		logic [SLICES_W-1:0] slice_count;
		logic [PIX_W-1:0] pixel_in_slice;
		logic [IDX_W-1:0] slice_counter;
		logic signed [SAMPLE_W-1:0] slice_min;
		logic signed [SAMPLE_W-1:0] slice_max;
		logic signed [SAMPLE_W-1:0] cube_min;
		logic signed [SAMPLE_W-1:0] cube_max;
		logic slice_has_valid;
		logic cube_has_valid;
		logic [CNT_W-1:0] blank_counter;
		logic [CNT_W-1:0] valid_counter;
		logic [SUM_W-1:0] square_sum;
		logic square_sum_saturated;
		res_t pending_summaries[$];
		int mismatches;

		function new();
			plane_size = 1;
			slice_count = 1;
			mismatches = 0;
			clear_cube();
		endfunction

		function void clear_cube();
			pixel_in_slice = '0;
			slice_counter = '0;
			slice_min = SAMPLE_MAX;
			slice_max = SAMPLE_MIN;
			cube_min = SAMPLE_MAX;
			cube_max = SAMPLE_MIN;
			slice_has_valid = 1'b0;
			cube_has_valid = 1'b0;
			blank_counter = '0;
			valid_counter = '0;
			square_sum = '0;
			square_sum_saturated = 1'b0;
		endfunction

		function void write_register(int idx, logic [DATA_W-1:0] value);
			if (idx == REG_PLANE_SIZE) begin
				plane_size = value[PLANE_W-1:0];
			end else if (idx == REG_SLICE_COUNT) begin
				slice_count = value[SLICES_W-1:0];
			end
		endfunction

		function int pending();
			return pending_summaries.size();
		endfunction

		function void take_pixel(logic signed [SAMPLE_W-1:0] sample, logic blank);
			logic signed [SAMPLE_W:0] wide;
			logic [SQ_W-1:0] square;
			logic [SUM_W:0] total;
			logic [SUM_W-1:0] mean;
			logic [SUM_W-1:0] trial;
			logic [ROOT_W-1:0] root;
			longint plane;
			longint slices;
			logic cube_done;
			res_t summary;

			plane = plane_size;
			if (plane < 1) plane = 1;
			if (plane > longint'(MAX_PLANE)) plane = MAX_PLANE;
			slices = slice_count;
			if (slices < 1) slices = 1;
			if (slices > longint'(MAX_SLICES)) slices = MAX_SLICES;

			if (blank) begin
				if (blank_counter != CNT_MAX) blank_counter++;
			end else begin
				wide = sample;
				if (wide < 0) wide = -wide;
				square = SQ_W'(unsigned'(wide)) * SQ_W'(unsigned'(wide));
				if (sample < slice_min) slice_min = sample;
				if (sample > slice_max) slice_max = sample;
				if (sample < cube_min) cube_min = sample;
				if (sample > cube_max) cube_max = sample;
				slice_has_valid = 1'b1;
				cube_has_valid = 1'b1;
				if (valid_counter != CNT_MAX) valid_counter++;
				total = {1'b0, square_sum} + (SUM_W+1)'(square);
				if (total[SUM_W]) begin
					square_sum = SUM_MAX;
					square_sum_saturated = 1'b1;
				end else begin
					square_sum = total[SUM_W-1:0];
				end
			end

			if (longint'(pixel_in_slice) + 1 < plane) begin
				pixel_in_slice++;
				return;
			end

			cube_done = longint'(slice_counter) + 1 >= slices;
			summary = '0;
			summary.kind = KIND_SLICE;
			summary.slice_index = slice_counter;
			summary.min_value = slice_min;
			summary.max_value = slice_max;
			summary.any_valid = slice_has_valid;
			summary.last = !cube_done;
			pending_summaries.push_back(summary);
			pixel_in_slice = '0;
			slice_min = SAMPLE_MAX;
			slice_max = SAMPLE_MIN;
			slice_has_valid = 1'b0;

			if (!cube_done) begin
				slice_counter++;
				return;
			end

			// The RMS is the integer square root of the truncated mean square.
			root = '0;
			if (valid_counter != 0) begin
				mean = square_sum / SUM_W'(valid_counter);
				for (int b = ROOT_W - 1; b >= 0; b--) begin
					trial = SUM_W'(root | (ROOT_W'(1) << b));
					if (trial * trial <= mean) root = root | (ROOT_W'(1) << b);
				end
			end
			summary = '0;
			summary.kind = KIND_CUBE;
			summary.min_value = cube_min;
			summary.max_value = cube_max;
			summary.any_valid = cube_has_valid;
			summary.blank_count = blank_counter;
			summary.rms_value = (root > ROOT_W'(RMS_MAX)) ? RMS_MAX : root[RMS_W-1:0];
			summary.sum_saturated = square_sum_saturated;
			summary.last = 1'b1;
			pending_summaries.push_back(summary);
			clear_cube();
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task compare(string name, logic [63:0] seen, logic [63:0] wanted);
			if (seen !== wanted) begin
				report($sformatf("%s got %0h, expected %0h", name, seen, wanted));
			end
		endtask

		task check_summary(res_t seen);
			res_t wanted;
			if (pending_summaries.size() == 0) begin
				report("summary transfer with no summary expected");
				return;
			end
			wanted = pending_summaries.pop_front();
			compare("kind", seen.kind, wanted.kind);
			compare("slice_index", seen.slice_index, wanted.slice_index);
			compare("min_value", seen.min_value, wanted.min_value);
			compare("max_value", seen.max_value, wanted.max_value);
			compare("any_valid", seen.any_valid, wanted.any_valid);
			compare("blank_count", seen.blank_count, wanted.blank_count);
			compare("rms_value", seen.rms_value, wanted.rms_value);
			compare("sum_saturated", seen.sum_saturated, wanted.sum_saturated);
			compare("last", seen.last, wanted.last);
		endtask
	endclass

endpackage

// ===== tb/tb_cube_slice_stats_rms_core.sv =====
module tb_cube_slice_stats_rms_core;
	import cssr_pkg::*;
	import cssr_stats_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 120;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic steady;
	int cycles = 0;
	cube_stats_board stats;

	cssr_in_if pix();
	cssr_out_if res();

	cube_slice_stats_rms_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pixels(pix),
		.results(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 70) return 0;
		if (roll < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2, 3: return SAMPLE_W'($urandom_range(0, 1023)) - SAMPLE_W'(512);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	initial begin
		int stall;
		stall = 0;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				res.ready <= 1'b0;
				stall--;
			end else begin
				res.ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		res_t seen;
		if (arst_n && res.valid === 1'b1 && res.ready === 1'b1) begin
			seen.kind = res.kind;
			seen.slice_index = res.slice_index;
			seen.min_value = res.min_value;
			seen.max_value = res.max_value;
			seen.any_valid = res.any_valid;
			seen.blank_count = res.blank_count;
			seen.rms_value = res.rms_value;
			seen.sum_saturated = res.sum_saturated;
			seen.last = res.last;
			stats.check_summary(seen);
		end
	end

	task automatic send_pixel(input logic signed [SAMPLE_W-1:0] sample, input logic blank);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix.valid <= 1'b1;
		pix.sample <= sample;
		pix.blank <= blank;
		do @(posedge clk); while (pix.ready !== 1'b1);
		stats.take_pixel(sample, blank);
		@(negedge clk);
	endtask

	task automatic settle(input int extra);
		pix.valid <= 1'b0;
		@(negedge clk);
		while (stats.pending() != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_register(input int idx, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * idx);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		stats.write_register(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_shape(input logic [DATA_W-1:0] plane, input logic [DATA_W-1:0] slices);
		settle(SETTLE_CYCLES);
		write_register(REG_PLANE_SIZE, plane);
		write_register(REG_SLICE_COUNT, slices);
	endtask

	task automatic run_cubes(input int plane, input int slices, input int cubes,
			input int blank_pct, input int hold_at);
		set_shape(plane, slices);
		for (int i = 0; i < cubes * plane * slices; i++) begin
			if (i == hold_at) settle(0);
			send_pixel(pick_sample(), $urandom_range(0, 99) < blank_pct);
		end
	endtask

	initial begin
		int plane;
		int slices;
		stats = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix.valid = 1'b0;
		pix.sample = '0;
		pix.blank = 1'b0;
		steady = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// With the reset shape every pixel is a whole cube.
		send_pixel('0, 1'b0);
		send_pixel(SAMPLE_MAX, 1'b0);
		send_pixel(SAMPLE_MIN, 1'b0);
		send_pixel(SAMPLE_W'(-1), 1'b0);
		send_pixel(SAMPLE_W'(1), 1'b0);
		send_pixel(SAMPLE_W'(24'h555555), 1'b0);
		send_pixel(SAMPLE_W'(24'hAAAAAA), 1'b0);
		send_pixel(SAMPLE_MAX, 1'b1);
		send_pixel('0, 1'b1);

		// Zero in both registers is taken as one.
		set_shape(0, 0);
		send_pixel(SAMPLE_W'(100), 1'b0);
		send_pixel(SAMPLE_W'(-100), 1'b1);

		// A cube of the most negative value drives the RMS past its range.
		set_shape(3, 2);
		repeat (6) send_pixel(SAMPLE_MIN, 1'b0);
		repeat (3) send_pixel(pick_sample(), 1'b1);
		send_pixel(SAMPLE_MAX, 1'b0);
		send_pixel(SAMPLE_W'(-5), 1'b0);
		send_pixel(SAMPLE_W'(7), 1'b0);

		run_cubes(16, 3, 1, 15, 20);
		for (int p = 0; p < 7; p++) begin
			steady = (p % 3 == 2);
			plane = $urandom_range(1, 10);
			slices = $urandom_range(1, 5);
			run_cubes(plane, slices, 75 / (plane * slices) + 1,
				(p == 4) ? 100 : $urandom_range(0, 40), (p == 1) ? 30 : -1);
		end
		steady = 1'b0;

		// Oversized values clamp to the largest plane and slice count;
		// these pixels finish no slice.
		set_shape(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		repeat (8) send_pixel(pick_sample(), $urandom_range(0, 1));

		settle(SETTLE_CYCLES);
		if (stats.mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
